// File: sv/wmmn_pkg.sv
// Types and constants shared by the window min-max normalizer.
// No dependencies; every other file of the block but wmmn_ram imports this package.
package wmmn_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int VALUE_W   = 17;
   localparam int RANGE_W   = 17;
   localparam int LEN_W     = 9;
   localparam int DIV_STEPS = 16;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   localparam logic [LEN_W-1:0]   LEN_RESET = 9'd150;
   localparam logic [VALUE_W-1:0] ONE_VALUE = 17'h10000;
   localparam logic [STEP_W-1:0]  LAST_STEP = STEP_W'(DIV_STEPS - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_COMMIT,
      ST_DIVIDE,
      ST_OUTPUT
   } state_type;

   typedef struct packed {
      logic capture;
      logic commit;
      logic div_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic has_result;
      logic divide;
      logic out_busy;
   } status_type;

endpackage

// File: sv/wmmn_req_if.sv
// Input channel: valid/ready handshake carrying one raw sample.
// Depends on wmmn_pkg.
interface wmmn_req_if;
   import wmmn_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

// File: sv/wmmn_rsp_if.sv
// Result channel: valid/ready handshake carrying one normalized result.
// Depends on wmmn_pkg.
interface wmmn_rsp_if;
   import wmmn_pkg::*;

   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] normalized_value;
   logic               last_of_window;
   logic               flat_window;

   modport source (output valid, output normalized_value, output last_of_window,
                   output flat_window, input ready);
   modport sink   (input valid, input normalized_value, input last_of_window,
                   input flat_window, output ready);
endinterface

// File: sv/wmmn_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wmmn_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_addr,
   input  logic [WIDTH-1:0]         write_data,
   input  logic [$clog2(DEPTH)-1:0] read_addr,
   output logic [WIDTH-1:0]         read_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_addr] <= write_data;
      end
      read_data_ff <= mem_ff[read_addr];
   end

   assign read_data = read_data_ff;
endmodule

// File: sv/wmmn_ctrl.sv
// Controller state machine: sequences read, commit, divide and output.
// Depends on wmmn_pkg; drives the datapath through cmd_type/status_type.
module wmmn_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  wmmn_pkg::status_type status,
   output wmmn_pkg::cmd_type    cmd
);
   import wmmn_pkg::*;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            step_in    = '0;
            if (!status.has_result) begin
               state_in = ST_IDLE;
            end else if (status.divide) begin
               state_in = ST_DIVIDE;
            end else begin
               state_in = ST_OUTPUT;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            if (!status.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.commit, cmd.div_step, cmd.out_load}))
      else $error("controller issued more than one command");

   a_capture_read: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> state_ff == ST_READ)
      else $error("capture not followed by RAM read");

   a_divide_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE && step_ff == LAST_STEP) |=> state_ff == ST_OUTPUT)
      else $error("divide did not finish after the last step");
endmodule

// File: sv/wmmn_datapath.sv
// Datapath: length register, sample store, running and held min/range,
// serial restoring divider and result register. Depends on wmmn_pkg, wmmn_ram.
module wmmn_datapath #(
   parameter int WINDOW_MAX = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [wmmn_pkg::LEN_W-1:0]    csr_write_data,
   input  wmmn_pkg::cmd_type             cmd,
   output wmmn_pkg::status_type          status,
   input  logic signed [wmmn_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [wmmn_pkg::VALUE_W-1:0]  rsp_normalized_value,
   output logic                          rsp_last_of_window,
   output logic                          rsp_flat_window
);
   import wmmn_pkg::*;

   localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int CMP_W = (IDX_W + 1 > LEN_W) ? IDX_W + 1 : LEN_W;

   logic [LEN_W-1:0]           len_ff;
   logic [IDX_W-1:0]           write_index_ff;
   logic [IDX_W-1:0]           idx_ff;
   logic                       last_ff;
   logic signed [SAMPLE_W-1:0] sample_ff;
   logic signed [SAMPLE_W-1:0] run_min_ff, run_max_ff;
   logic signed [SAMPLE_W-1:0] held_min_ff;
   logic [RANGE_W-1:0]         held_range_ff;
   logic                       prev_valid_ff;
   logic [RANGE_W-1:0]         rem_ff, div_ff;
   logic [VALUE_W-1:0]         quot_ff;
   logic                       flat_ff;
   logic                       rsp_valid_ff;
   logic [VALUE_W-1:0]         rsp_value_ff;
   logic                       rsp_last_ff, rsp_flat_ff;

   logic [CMP_W-1:0]           eff_len;
   logic                       next_last;
   logic [SAMPLE_W-1:0]        ram_rdata;
   logic signed [SAMPLE_W-1:0] old_sample;
   logic signed [SAMPLE_W-1:0] run_min_in, run_max_in;
   logic signed [RANGE_W-1:0]  diff;
   logic [RANGE_W-1:0]         num;
   logic [RANGE_W:0]           rem_shift;
   logic                       sub_ok;

   always_comb begin
      eff_len = CMP_W'(len_ff);
      if (eff_len < CMP_W'(2)) begin
         eff_len = CMP_W'(2);
      end else if (eff_len > CMP_W'(WINDOW_MAX)) begin
         eff_len = CMP_W'(WINDOW_MAX);
      end
      next_last = (CMP_W'(write_index_ff) + CMP_W'(1)) >= eff_len;
   end

   wmmn_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (WINDOW_MAX)
   ) u_store (
      .clock        (clock),
      .write_enable (cmd.commit),
      .write_addr   (idx_ff),
      .write_data   (sample_ff),
      .read_addr    (idx_ff),
      .read_data    (ram_rdata)
   );

   always_comb begin
      old_sample = $signed(ram_rdata);
      if (idx_ff == '0) begin
         run_min_in = sample_ff;
         run_max_in = sample_ff;
      end else begin
         run_min_in = (sample_ff < run_min_ff) ? sample_ff : run_min_ff;
         run_max_in = (sample_ff > run_max_ff) ? sample_ff : run_max_ff;
      end
      diff = RANGE_W'(old_sample) - RANGE_W'(held_min_ff);
      if (diff < 0) begin
         num = '0;
      end else if ($unsigned(diff) > held_range_ff) begin
         num = held_range_ff;
      end else begin
         num = $unsigned(diff);
      end
      rem_shift = {rem_ff, 1'b0};
      sub_ok    = rem_shift >= {1'b0, div_ff};
   end

   assign status.has_result = prev_valid_ff;
   assign status.divide     = prev_valid_ff && (held_range_ff != '0) && (num != held_range_ff);
   assign status.out_busy   = rsp_valid_ff && !rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff         <= LEN_RESET;
         write_index_ff <= '0;
         prev_valid_ff  <= 1'b0;
         run_min_ff     <= '0;
         run_max_ff     <= '0;
         held_min_ff    <= '0;
         held_range_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            len_ff <= csr_write_data;
         end
         if (cmd.commit) begin
            run_min_ff <= run_min_in;
            run_max_ff <= run_max_in;
            if (last_ff) begin
               held_min_ff    <= run_min_in;
               held_range_ff  <= RANGE_W'(RANGE_W'(run_max_in) - RANGE_W'(run_min_in));
               prev_valid_ff  <= 1'b1;
               write_index_ff <= '0;
            end else begin
               write_index_ff <= idx_ff + 1'b1;
            end
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sample_ff <= req_sample;
         idx_ff    <= write_index_ff;
         last_ff   <= next_last;
      end
      if (cmd.commit) begin
         flat_ff <= (held_range_ff == '0);
         quot_ff <= ((held_range_ff != '0) && (num == held_range_ff)) ? ONE_VALUE : '0;
         rem_ff  <= num;
         div_ff  <= held_range_ff;
      end
      if (cmd.div_step) begin
         if (sub_ok) begin
            rem_ff  <= RANGE_W'(rem_shift - {1'b0, div_ff});
            quot_ff <= {quot_ff[VALUE_W-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_shift[RANGE_W-1:0];
            quot_ff <= {quot_ff[VALUE_W-2:0], 1'b0};
         end
      end
      if (cmd.out_load) begin
         rsp_value_ff <= quot_ff;
         rsp_last_ff  <= last_ff;
         rsp_flat_ff  <= flat_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_normalized_value = rsp_value_ff;
   assign rsp_last_of_window   = rsp_last_ff;
   assign rsp_flat_window      = rsp_flat_ff;

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(write_index_ff) < CMP_W'(WINDOW_MAX))
      else $error("write index beyond store depth");

   a_flat_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_flat_ff) |-> rsp_value_ff == '0)
      else $error("flat window result is not zero");

   a_value_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_value_ff <= ONE_VALUE)
      else $error("normalized value above one");

   a_remainder_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> rem_ff < div_ff)
      else $error("divider remainder not below divisor");
endmodule

// File: sv/window_min_max_normalizer_top.sv
// Windowed min-max normalizer top level: controller, datapath, channel ports.
// A sample is read, committed and, unless its result is flat or full scale, divided by
// the 16-step serial restoring divider before its result is presented; no result is given
// until a window is held. A new sample is taken only once the last one is through.
// Reset (synchronous, active high) clears the window, length = 150; store is not cleared.
// Depends on wmmn_pkg, wmmn_req_if, wmmn_rsp_if, wmmn_ctrl, wmmn_datapath.
module window_min_max_normalizer_top #(
   parameter int WINDOW_MAX = 256
) (
   input  logic                       clock,
   input  logic                       reset,
   wmmn_req_if.sink                   req_chan,
   wmmn_rsp_if.source                 rsp_chan,
   input  logic                       csr_write_enable,
   input  logic [wmmn_pkg::LEN_W-1:0] csr_write_data
);
   import wmmn_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       req_ready;

   wmmn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   wmmn_datapath #(
      .WINDOW_MAX (WINDOW_MAX)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .cmd                  (cmd),
      .status               (status),
      .req_sample           (req_chan.sample),
      .rsp_ready            (rsp_chan.ready),
      .rsp_valid            (rsp_chan.valid),
      .rsp_normalized_value (rsp_chan.normalized_value),
      .rsp_last_of_window   (rsp_chan.last_of_window),
      .rsp_flat_window      (rsp_chan.flat_window)
   );

   assign req_chan.ready = req_ready;
endmodule

// File: tb/tb_top.sv
// Self-checking bench for window_min_max_normalizer_top: random stalls on both channels,
// window length changes while idle, and a bit-true windowed min-max predictor.
// Depends on wmmn_pkg, wmmn_req_if, wmmn_rsp_if and the normalizer RTL.
module tb_top;
   import wmmn_pkg::*;

   localparam int STORE_DEPTH  = 256;
   localparam int DRAIN_CYCLES = 30;
   localparam int STALL_LIMIT  = 2000;
   localparam int RANDOM_ITEMS = 220;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               last;
      logic               flat;
   } norm_result_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_write_enable;
   logic [LEN_W-1:0]  csr_write_data;

   wmmn_req_if sample_chan ();
   wmmn_rsp_if norm_chan ();

   window_min_max_normalizer_top DUT (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (sample_chan),
      .rsp_chan         (norm_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // Predictor state
   logic signed [SAMPLE_W-1:0] win_store [STORE_DEPTH];
   int unsigned                win_index;
   int                         win_min;
   int                         win_max;
   int                         held_min;
   int unsigned                held_span;
   bit                         held_valid;
   logic [LEN_W-1:0]           length_setting;

   logic signed [SAMPLE_W-1:0] sample_q [$];
   norm_result_type            norm_expect_q [$];

   bit  sample_fired;
   bit  norm_fired;
   bit  sender_steady;
   bit  receiver_steady;
   int  send_wait;
   int  recv_stall;
   int  recv_draw;
   int  idle_cycles;
   int  mismatches = 0;
   int  samples_sent = 0;
   int  results_checked = 0;
   int  settings_used;

   always #1 clock = ~clock;

   function automatic void add_sample(logic signed [SAMPLE_W-1:0] s);
      sample_q.insert(sample_q.size(), s);
   endfunction

   function automatic int draw_wait(bit steady);
      return steady ? 0 : int'($urandom_range(0, 19));
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] draw_sample(int unsigned style,
                                                              logic signed [SAMPLE_W-1:0] base);
      case (style)
         0: return SAMPLE_W'($urandom);
         1: return base + SAMPLE_W'($urandom_range(0, 3));
         2: return base;
         default: begin
            case ($urandom_range(0, 2))
               0: return 16'sh8000;
               1: return 16'sh7FFF;
               default: return SAMPLE_W'($urandom);
            endcase
         end
      endcase
   endfunction

   function automatic void normalize_sample(logic signed [SAMPLE_W-1:0] x);
      int unsigned       span_len;
      int unsigned       idx;
      bit                closing;
      int                diff;
      longint unsigned   scaled;
      norm_result_type   res;
      span_len = length_setting;
      if (span_len < 2) span_len = 2;
      if (span_len > STORE_DEPTH) span_len = STORE_DEPTH;
      idx = (win_index >= STORE_DEPTH) ? 0 : win_index;
      closing = (idx + 1 >= span_len);
      if (held_valid) begin
         res.value = '0;
         res.last  = closing;
         res.flat  = (held_span == 0);
         if (held_span != 0) begin
            diff = int'(win_store[idx]) - held_min;
            if (diff < 0) diff = 0;
            if (diff > int'(held_span)) diff = int'(held_span);
            scaled = (longint'(diff) << 16) / held_span;
            res.value = scaled[VALUE_W-1:0];
         end
         norm_expect_q.insert(norm_expect_q.size(), res);
      end
      win_store[idx] = x;
      if (idx == 0) begin
         win_min = x;
         win_max = x;
      end else begin
         if (x > win_max) win_max = x;
         if (x < win_min) win_min = x;
      end
      if (closing) begin
         held_min   = win_min;
         held_span  = (win_max - win_min) & 17'h1FFFF;
         held_valid = 1'b1;
         win_index  = 0;
      end else begin
         win_index = idx + 1;
      end
   endfunction

   function automatic void check_result();
      norm_result_type want;
      results_checked++;
      if (norm_expect_q.size() == 0) begin
         $error("unexpected result: normalized_value %0d last %0b flat %0b",
                norm_chan.normalized_value, norm_chan.last_of_window, norm_chan.flat_window);
         mismatches++;
      end else begin
         want = norm_expect_q.pop_front();
         if (norm_chan.normalized_value !== want.value) begin
            $error("normalized_value: expected %0d, got %0d", want.value,
                   norm_chan.normalized_value);
            mismatches++;
         end
         if (norm_chan.last_of_window !== want.last) begin
            $error("last_of_window: expected %0b, got %0b", want.last, norm_chan.last_of_window);
            mismatches++;
         end
         if (norm_chan.flat_window !== want.flat) begin
            $error("flat_window: expected %0b, got %0b", want.flat, norm_chan.flat_window);
            mismatches++;
         end
      end
   endfunction

   // Monitor and predictor: sample everything at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         sample_fired   <= 1'b0;
         norm_fired     <= 1'b0;
         idle_cycles    <= 0;
         win_index      = 0;
         win_min        = 0;
         win_max        = 0;
         held_min       = 0;
         held_span      = 0;
         held_valid     = 1'b0;
         length_setting = LEN_RESET;
      end else begin
         sample_fired <= sample_chan.valid && sample_chan.ready;
         norm_fired   <= norm_chan.valid && norm_chan.ready;
         if (csr_write_enable) length_setting = csr_write_data;
         if (sample_chan.valid && sample_chan.ready) begin
            normalize_sample(sample_chan.sample);
            samples_sent++;
         end
         if (norm_chan.valid && norm_chan.ready) check_result();
         if ((sample_chan.valid && sample_chan.ready) || (norm_chan.valid && norm_chan.ready)
             || csr_write_enable) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   always @(posedge clock) begin
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Sample driver: advance on a transfer, hold the drawn gap after each item
   always @(negedge clock) begin
      if (reset) begin
         sample_chan.valid  <= 1'b0;
         sample_chan.sample <= '0;
         send_wait          <= 0;
      end else if (!sample_chan.valid || sample_fired) begin
         if (send_wait != 0) begin
            sample_chan.valid <= 1'b0;
            send_wait         <= send_wait - 1;
         end else if (sample_q.size() != 0) begin
            sample_chan.valid  <= 1'b1;
            sample_chan.sample <= sample_q.pop_front();
            send_wait          <= draw_wait(sender_steady);
         end else begin
            sample_chan.valid <= 1'b0;
         end
      end
   end

   // Result receiver: drop ready for the drawn stall after each transfer
   always @(negedge clock) begin
      if (reset) begin
         norm_chan.ready <= 1'b0;
         recv_stall      <= 0;
      end else if (norm_chan.ready && norm_fired) begin
         recv_draw = draw_wait(receiver_steady);
         if (recv_draw != 0) begin
            norm_chan.ready <= 1'b0;
            recv_stall      <= recv_draw - 1;
         end
      end else if (!norm_chan.ready) begin
         if (recv_stall == 0) norm_chan.ready <= 1'b1;
         else recv_stall <= recv_stall - 1;
      end
   end

   task automatic write_length(logic [LEN_W-1:0] len);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= len;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      settings_used++;
   endtask

   task automatic wait_drained();
      while (sample_q.size() != 0 || sample_chan.valid || norm_expect_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      logic [LEN_W-1:0]           extreme_lengths [5];
      logic [LEN_W-1:0]           len;
      logic signed [SAMPLE_W-1:0] base;
      int unsigned                style;
      int unsigned                count;
      int                         random_items;
      int                         phase;
      extreme_lengths = '{9'd2, 9'd256, 9'd511, 9'd257, 9'd0};
      reset            <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_write_data   <= '0;
      sender_steady   = 1'b0;
      receiver_steady = 1'b0;
      settings_used   = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Fill the whole store first so no later window reads an unwritten entry
      write_length(9'd300);
      for (int i = 0; i < STORE_DEPTH; i++) begin
         if (i == 2 || i == 4) add_sample(16'sh8000);
         else if (i == 3) add_sample(16'sh7FFF);
         else add_sample(SAMPLE_W'($urandom));
      end
      wait_drained();

      // Full scale, flat windows, length below range
      write_length(9'd0);
      add_sample(16'sh8000);
      add_sample(16'sh7FFF);
      add_sample(16'sd7);
      add_sample(16'sd7);
      add_sample(-16'sd1);
      add_sample(16'sd0);
      add_sample(16'sh7FFF);
      add_sample(16'sh7FFF);
      wait_drained();
      write_length(9'd1);
      add_sample(16'sh8000);
      add_sample(16'sh8001);
      add_sample(16'sd10);
      add_sample(16'sd20);
      wait_drained();

      // Stale entries outside the held range, then shrink the window mid-window
      write_length(9'd5);
      add_sample(16'sd100);
      add_sample(-16'sd200);
      add_sample(16'sd300);
      add_sample(16'sh7FFF);
      wait_drained();
      write_length(9'd2);
      add_sample(16'sd55);
      add_sample(-16'sd55);
      add_sample(16'sd1);
      wait_drained();

      random_items = 0;
      phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         if (phase < 5) begin
            len = extreme_lengths[phase];
         end else begin
            case ($urandom_range(0, 9))
               0: len = LEN_W'($urandom_range(0, 1));
               1: len = LEN_W'($urandom_range(257, 511));
               2: len = 9'd256;
               3: len = LEN_W'($urandom_range(17, 64));
               default: len = LEN_W'($urandom_range(2, 16));
            endcase
         end
         write_length(len);
         style = $urandom_range(0, 3);
         base  = SAMPLE_W'($urandom);
         sender_steady   = ($urandom_range(0, 3) == 0);
         receiver_steady = ($urandom_range(0, 3) == 0);
         count = $urandom_range(5, 60);
         repeat (count) add_sample(draw_sample(style, base));
         random_items += count;
         wait_drained();
         phase++;
      end

      $display("Sent %0d samples over %0d window length settings, checked %0d results",
               samples_sent, settings_used, results_checked);
      $display("Covered full-scale, flat, saturated stale and mid-window length changes");
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// File: filelist.f
sv/wmmn_pkg.sv
sv/wmmn_req_if.sv
sv/wmmn_rsp_if.sv
sv/wmmn_ram.sv
sv/wmmn_ctrl.sv
sv/wmmn_datapath.sv
sv/window_min_max_normalizer_top.sv
tb/tb_top.sv
